// ===== design/spmf_pkg.sv =====
// Package for the strict priority multi-FIFO queue: sizes, codes, types
// and pointer helpers.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps

package spmf_pkg;

    localparam int LEVELS     = 4;
    localparam int FIFO_DEPTH = 8;

    localparam int VALUE_W = 32;
    localparam int LVL_W   = 2;
    localparam int TDATA_W = ((VALUE_W + LVL_W + 7) / 8) * 8;

    localparam int LIDX_W      = $clog2(LEVELS);
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int STORE_DEPTH = LEVELS * FIFO_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef logic [LIDX_W-1:0]  lvl_idx_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [VALUE_W-1:0] value_t;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    // Write and read requests from the queue control to the entry store.
    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        logic  rd_en;
        addr_t rd_addr;
    } store_req_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Entries of one level sit in one contiguous block of the store.
    function automatic addr_t entry_addr(input lvl_idx_t idx, input ptr_t p);
        addr_t r;
        r = ADDR_W'(ADDR_W'(idx) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(p));
        return r;
    endfunction

endpackage

// ===== design/spmf_store.sv =====
// Entry store of the priority queue: one memory holding every level's FIFO.
// One write port, one read port with registered read data; uses spmf_pkg.
`timescale 1ns / 1ps

module spmf_store (
    input  logic                aclk,
    input  spmf_pkg::store_req_t req,
    input  spmf_pkg::value_t    wr_data,
    output spmf_pkg::value_t    rd_data
);
    import spmf_pkg::*;

    value_t mem_reg [STORE_DEPTH];
    value_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/strict_priority_multi_fifo.sv =====
// Strict priority queue with one circular FIFO per level, level 0 highest.
// The result of a request is registered and appears in the cycle after it is accepted.
// Throughput: one request per cycle while m_tready is high; the single output
// register and the one-port store read set this figure.
// Reset clears head, tail and fill count of every level; the entry store is
// not cleared and holds data only where an insert has written it.
`timescale 1ns / 1ps

module strict_priority_multi_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spmf_pkg::TDATA_W-1:0]  s_tdata,   // value_in[31:0], level_in[33:32]
    input  logic                          s_tuser,   // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spmf_pkg::TDATA_W-1:0]  m_tdata,   // value_out[31:0], level_out[33:32]
    output logic [1:0]                    m_tuser    // status
);
    import spmf_pkg::*;

    ptr_t head_reg  [LEVELS];
    ptr_t head_next [LEVELS];
    ptr_t tail_reg  [LEVELS];
    ptr_t tail_next [LEVELS];
    cnt_t count_reg [LEVELS];
    cnt_t count_next[LEVELS];

    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [LVL_W-1:0] out_level_reg;

    logic             s_mode;
    value_t           s_value_in;
    logic [LVL_W-1:0] s_level_in;
    logic             in_accept;
    lvl_idx_t         ins_idx;
    logic             level_ok;
    logic             found;
    lvl_idx_t         found_idx;
    status_t          res_status;
    logic [LVL_W-1:0] res_level;
    store_req_t       store_req;
    value_t           rd_data;

    assign s_mode     = s_tuser;
    assign s_value_in = s_tdata[VALUE_W-1:0];
    assign s_level_in = s_tdata[VALUE_W+LVL_W-1:VALUE_W];

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign ins_idx  = LIDX_W'(s_level_in);
    assign level_ok = (int'(s_level_in) < LEVELS);

    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        // Scan from the lowest priority up so the highest non-empty level wins.
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (count_reg[i] != '0) begin
                found     = 1'b1;
                found_idx = LIDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
        end
        store_req  = '0;
        res_status = ST_INSERTED;
        res_level  = '0;

        if (s_mode == MODE_INSERT) begin
            if (!level_ok || count_reg[ins_idx] == CNT_W'(FIFO_DEPTH)) begin
                res_status = ST_OVERFLOW;
            end else begin
                res_status = ST_INSERTED;
                if (in_accept) begin
                    store_req.wr_en     = 1'b1;
                    store_req.wr_addr   = entry_addr(ins_idx, tail_reg[ins_idx]);
                    tail_next[ins_idx]  = next_ptr(tail_reg[ins_idx]);
                    count_next[ins_idx] = count_reg[ins_idx] + CNT_W'(1);
                end
            end
        end else if (found) begin
            res_status = ST_REMOVED;
            res_level  = LVL_W'(found_idx);
            if (in_accept) begin
                store_req.rd_en       = 1'b1;
                store_req.rd_addr     = entry_addr(found_idx, head_reg[found_idx]);
                head_next[found_idx]  = next_ptr(head_reg[found_idx]);
                count_next[found_idx] = count_reg[found_idx] - CNT_W'(1);
            end
        end else begin
            res_status = ST_UNDERFLOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
            if (in_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_status_reg <= res_status;
            out_level_reg  <= res_level;
        end
    end

    spmf_store u_store (
        .aclk    (aclk),
        .req     (store_req),
        .wr_data (s_value_in),
        .rd_data (rd_data)
    );

    // The store's read register is loaded only for a successful remove, so the
    // value is masked for every other outcome.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = TDATA_W'({out_level_reg,
                                (out_status_reg == ST_REMOVED) ? rd_data : '0});

endmodule

// ===== design/spmf_checker.sv =====
// Port-level checker for strict_priority_multi_fifo, attached by a bind.
// Uses spmf_pkg for mode and status codes.
`timescale 1ns / 1ps

module spmf_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [spmf_pkg::TDATA_W-1:0] s_tdata,
    input logic                         s_tuser,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [spmf_pkg::TDATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser
);
    import spmf_pkg::*;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Every accepted request shows its result in the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("result missing one cycle after request");

    a_insert_status: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_INSERT |=>
            m_tuser == ST_INSERTED || m_tuser == ST_OVERFLOW)
        else $error("insert request gave a remove status");

    a_remove_status: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == MODE_REMOVE |=>
            m_tuser == ST_REMOVED || m_tuser == ST_UNDERFLOW)
        else $error("remove request gave an insert status");

    // Value and level are zero unless an entry was actually removed.
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_REMOVED |-> m_tdata == '0)
        else $error("nonzero payload on a result without removal");

endmodule

bind strict_priority_multi_fifo spmf_checker u_spmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
